### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh: concurrent assertion helpers
// Clocked assertions with an asynchronous active-low reset as the disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be true at a rising edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	`ASSERT_CLK(lbl, clk, rst_n, !(cond), msg)

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

### rtl/core/hse_pkg.sv
// ----------------------------------------------------------------------------
// hse_pkg: shared definitions for the heap sort engine
// Capacity, widths, data types and sequencer states.
// ----------------------------------------------------------------------------
package hse_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CHILD_W  = IDX_W + 2;
	localparam int VALUE_W  = 32;
	localparam int POS_W    = 6;

	typedef logic [IDX_W-1:0]          idx_t;
	typedef logic [CNT_W-1:0]          cnt_t;
	typedef logic [CHILD_W-1:0]        child_t;
	typedef logic signed [VALUE_W-1:0] value_t;
	typedef logic [POS_W-1:0]          pos_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UP_CMP,
		ST_UP_FIN,
		ST_SD_START,
		ST_SD_LOAD,
		ST_SD_CMP
	} state_t;

endpackage

### rtl/core/hse_in_if.sv
// ----------------------------------------------------------------------------
// hse_in_if: input channel of the heap sort engine
// One transaction carries a value and the flag that closes the set.
// ----------------------------------------------------------------------------
interface hse_in_if;

	logic            valid;
	logic            ready;
	hse_pkg::value_t value;
	logic            last;

	modport source (output valid, output value, output last, input ready);
	modport sink (input valid, input value, input last, output ready);

endinterface

### rtl/core/hse_out_if.sv
// ----------------------------------------------------------------------------
// hse_out_if: result channel of the heap sort engine
// One transaction carries an extracted value, its sorted position and the final and overflow flags.
// ----------------------------------------------------------------------------
interface hse_out_if;

	logic            valid;
	logic            ready;
	hse_pkg::value_t sorted_value;
	hse_pkg::pos_t   position;
	logic            final_res;
	logic            overflow;

	modport source (output valid, output sorted_value, output position,
		output final_res, output overflow, input ready);
	modport sink (input valid, input sorted_value, input position,
		input final_res, input overflow, output ready);

endinterface

### rtl/core/heap_sort_engine.sv
// ----------------------------------------------------------------------------
// heap_sort_engine: binary max-heap sort of signed 32-bit values
// Insert: one parent compare per cycle on the heap RAM until the new value settles.
// Sort: per result, load root and last, emit root, sift down; stalls while a result waits.
// Reset clears count, flags and result valid; heap contents stay undefined, no clear pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module heap_sort_engine (
	input  logic      clk,
	input  logic      arst_n,
	hse_in_if.sink    item,
	hse_out_if.source result
);

	hse_pkg::state_t state_q, state_d;
	hse_pkg::cnt_t   cnt_q, cnt_d;
	hse_pkg::idx_t   pos_q, pos_d;
	hse_pkg::value_t carry_q, carry_d;
	logic            last_q, last_d;
	logic            ovf_q, ovf_d;

	logic            out_valid_q, out_valid_d;
	hse_pkg::value_t out_value_q, out_value_d;
	hse_pkg::pos_t   out_pos_q, out_pos_d;
	logic            out_final_q, out_final_d;
	logic            out_ovf_q, out_ovf_d;

	// Heap RAM: one write port, two registered read ports.
	hse_pkg::value_t heap_mem [hse_pkg::CAPACITY];
	hse_pkg::value_t rdata_a_q, rdata_b_q;
	hse_pkg::idx_t   raddr_a, raddr_b, waddr;
	hse_pkg::value_t wdata;
	logic            we;

	hse_pkg::idx_t   parent;
	hse_pkg::cnt_t   last_idx;
	hse_pkg::child_t left_idx, right_idx, child_idx, next_left;
	logic            take_left, take_right;
	hse_pkg::value_t big_val;

	always_ff @(posedge clk) begin
		if (we) begin
			heap_mem[waddr] <= wdata;
		end
		rdata_a_q <= heap_mem[raddr_a];
		rdata_b_q <= heap_mem[raddr_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= hse_pkg::ST_IDLE;
			cnt_q       <= '0;
			pos_q       <= '0;
			last_q      <= 1'b0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			pos_q       <= pos_d;
			last_q      <= last_d;
			ovf_q       <= ovf_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		carry_q     <= carry_d;
		out_value_q <= out_value_d;
		out_pos_q   <= out_pos_d;
		out_final_q <= out_final_d;
		out_ovf_q   <= out_ovf_d;
	end

	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		pos_d       = pos_q;
		carry_d     = carry_q;
		last_d      = last_q;
		ovf_d       = ovf_q;
		out_valid_d = out_valid_q && !result.ready;
		out_value_d = out_value_q;
		out_pos_d   = out_pos_q;
		out_final_d = out_final_q;
		out_ovf_d   = out_ovf_q;
		raddr_a     = '0;
		raddr_b     = '0;
		we          = 1'b0;
		waddr       = pos_q;
		wdata       = carry_q;
		item.ready  = 1'b0;

		parent     = hse_pkg::IDX_W'((pos_q - 1'b1) >> 1);
		last_idx   = cnt_q - 1'b1;
		left_idx   = {1'b0, pos_q, 1'b1};
		right_idx  = left_idx + 1'b1;
		take_left  = (left_idx < hse_pkg::CHILD_W'(cnt_q)) && (rdata_a_q > carry_q);
		big_val    = take_left ? rdata_a_q : carry_q;
		take_right = (right_idx < hse_pkg::CHILD_W'(cnt_q)) && (rdata_b_q > big_val);
		child_idx  = take_right ? right_idx : left_idx;
		next_left  = {1'b0, child_idx[hse_pkg::IDX_W-1:0], 1'b1};

		unique case (state_q)
			hse_pkg::ST_IDLE: begin
				item.ready = 1'b1;
				if (item.valid) begin
					last_d = item.last;
					if (cnt_q < hse_pkg::CNT_W'(hse_pkg::CAPACITY)) begin
						cnt_d   = cnt_q + 1'b1;
						carry_d = item.value;
						pos_d   = cnt_q[hse_pkg::IDX_W-1:0];
						if (cnt_q == '0) begin
							we      = 1'b1;
							waddr   = '0;
							wdata   = item.value;
							state_d = item.last ? hse_pkg::ST_SD_START : hse_pkg::ST_IDLE;
						end else begin
							raddr_a = hse_pkg::IDX_W'((cnt_q - 1'b1) >> 1);
							state_d = hse_pkg::ST_UP_CMP;
						end
					end else begin
						ovf_d   = 1'b1;
						state_d = item.last ? hse_pkg::ST_SD_START : hse_pkg::ST_IDLE;
					end
				end
			end
			hse_pkg::ST_UP_CMP: begin
				we = 1'b1;
				if (carry_q > rdata_a_q) begin
					// Parent moves down into the hole; the new value climbs.
					wdata   = rdata_a_q;
					pos_d   = parent;
					raddr_a = hse_pkg::IDX_W'((parent - 1'b1) >> 1);
					if (parent == '0) begin
						state_d = hse_pkg::ST_UP_FIN;
					end
				end else begin
					state_d = last_q ? hse_pkg::ST_SD_START : hse_pkg::ST_IDLE;
				end
			end
			hse_pkg::ST_UP_FIN: begin
				we      = 1'b1;
				state_d = last_q ? hse_pkg::ST_SD_START : hse_pkg::ST_IDLE;
			end
			hse_pkg::ST_SD_START: begin
				// The result register is free by the time the root is loaded.
				if (!out_valid_q || result.ready) begin
					raddr_a = '0;
					raddr_b = last_idx[hse_pkg::IDX_W-1:0];
					state_d = hse_pkg::ST_SD_LOAD;
				end
			end
			hse_pkg::ST_SD_LOAD: begin
				out_valid_d = 1'b1;
				out_value_d = rdata_a_q;
				out_pos_d   = hse_pkg::POS_W'(last_idx);
				out_final_d = (last_idx == '0);
				out_ovf_d   = ovf_q;
				cnt_d       = last_idx;
				carry_d     = rdata_b_q;
				pos_d       = '0;
				if (last_idx == '0) begin
					ovf_d   = 1'b0;
					last_d  = 1'b0;
					state_d = hse_pkg::ST_IDLE;
				end else begin
					raddr_a = hse_pkg::IDX_W'(1);
					raddr_b = hse_pkg::IDX_W'(2);
					state_d = hse_pkg::ST_SD_CMP;
				end
			end
			hse_pkg::ST_SD_CMP: begin
				we = 1'b1;
				if (take_left || take_right) begin
					// Larger child moves up; fetch the children of its old slot.
					wdata   = take_right ? rdata_b_q : rdata_a_q;
					pos_d   = child_idx[hse_pkg::IDX_W-1:0];
					raddr_a = next_left[hse_pkg::IDX_W-1:0];
					raddr_b = hse_pkg::IDX_W'(next_left + 1'b1);
				end else begin
					state_d = hse_pkg::ST_SD_START;
				end
			end
			default: begin
				state_d = hse_pkg::ST_IDLE;
			end
		endcase
	end

	assign result.valid        = out_valid_q;
	assign result.sorted_value = out_value_q;
	assign result.position     = out_pos_q;
	assign result.final_res    = out_final_q;
	assign result.overflow     = out_ovf_q;

	`ASSERT_NEVER(a_cnt_range, clk, arst_n, cnt_q > hse_pkg::CNT_W'(hse_pkg::CAPACITY), "heap count above capacity")
	`ASSERT_CLK(a_load_free, clk, arst_n, (state_q == hse_pkg::ST_SD_LOAD) |-> !out_valid_q, "result register overwritten")
	`ASSERT_CLK(a_up_pos, clk, arst_n, (state_q == hse_pkg::ST_UP_CMP) |-> (hse_pkg::CNT_W'(pos_q) < cnt_q), "sift-up position outside heap")
	`ASSERT_CLK(a_run_end, clk, arst_n, (state_q == hse_pkg::ST_SD_LOAD && cnt_q == hse_pkg::CNT_W'(1)) |=> (state_q == hse_pkg::ST_IDLE && cnt_q == '0 && !ovf_q), "run did not close")

endmodule
